[rtl/core/ssd_pkg.sv]
// shared types, constants and the character font for the seven-segment scan driver
// no dependencies; imported by ssd_digit_cell and seven_segment_scan_driver_top
package ssd_pkg;

   localparam int MASK_BITS   = 12;
   localparam int SEG_BITS    = 3;
   localparam int CODE_BITS   = 6;
   localparam int INDEX_BITS  = 4;
   localparam int BRIGHT_BITS = 7;
   localparam int COUNT_BITS  = 16;
   localparam int FONT_SIZE   = 41;

   localparam logic [SEG_BITS-1:0] SEG_POINT = 3'd7;

   typedef enum logic {
      MODE_TICK  = 1'b0,
      MODE_WRITE = 1'b1
   } mode_type;

   typedef struct packed {
      logic                  mode;
      logic [INDEX_BITS-1:0] digit_index;
      logic [CODE_BITS-1:0]  char_code;
      logic                  point_on;
   } req_type;

   typedef struct packed {
      logic [SEG_BITS-1:0]  segment_number;
      logic [MASK_BITS-1:0] digit_mask;
      logic                 last_scan;
   } rsp_type;

   // digit write travelling to every cell
   typedef struct packed {
      logic                  valid;
      logic [INDEX_BITS-1:0] index;
      logic [CODE_BITS-1:0]  code;
      logic                  point;
   } wr_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic [SEG_BITS-1:0]  segment;
      logic [MASK_BITS-1:0] mask;
   } scan_type;

   // segments a..g in bits 0..6; codes past the table are blank
   function automatic logic [7:0] font_lookup(input logic [CODE_BITS-1:0] code);
      logic [7:0] pattern;
      case (code)
         6'd0:  pattern = 8'h3F;
         6'd1:  pattern = 8'h06;
         6'd2:  pattern = 8'h5B;
         6'd3:  pattern = 8'h4F;
         6'd4:  pattern = 8'h66;
         6'd5:  pattern = 8'h6D;
         6'd6:  pattern = 8'h7D;
         6'd7:  pattern = 8'h07;
         6'd8:  pattern = 8'h7F;
         6'd9:  pattern = 8'h6F;
         6'd10: pattern = 8'h77;
         6'd11: pattern = 8'h7C;
         6'd12: pattern = 8'h39;
         6'd13: pattern = 8'h5E;
         6'd14: pattern = 8'h79;
         6'd15: pattern = 8'h71;
         6'd16: pattern = 8'h7D;
         6'd17: pattern = 8'h74;
         6'd18: pattern = 8'h04;
         6'd19: pattern = 8'h1E;
         6'd21: pattern = 8'h38;
         6'd23: pattern = 8'h54;
         6'd24: pattern = 8'h5C;
         6'd25: pattern = 8'h73;
         6'd27: pattern = 8'h50;
         6'd29: pattern = 8'h78;
         6'd30: pattern = 8'h3E;
         6'd36: pattern = 8'h40;
         6'd38: pattern = 8'h63;
         6'd39: pattern = 8'h37;
         6'd40: pattern = 8'h30;
         default: pattern = 8'h00;
      endcase
      return pattern;
   endfunction

endpackage

[rtl/core/ssd_digit_cell.sv]
// one digit position: holds its character code and point flag, adds its bit to a passing scan token
// depends on ssd_pkg
module ssd_digit_cell #(
   parameter int POSITION = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ssd_pkg::wr_type   wr,
   input  ssd_pkg::scan_type scan_in,
   output ssd_pkg::scan_type scan_out
);
   import ssd_pkg::*;

   // positions past the mask width never show
   localparam logic [MASK_BITS-1:0] POS_BIT =
      (POSITION < MASK_BITS) ? (MASK_BITS'(1) << POSITION) : '0;
   localparam logic [INDEX_BITS-1:0] MY_INDEX = INDEX_BITS'(POSITION);

   logic [CODE_BITS-1:0] code_ff;
   logic                 point_ff;
   scan_type             token_ff;
   scan_type             token_in;
   logic [7:0]           pattern;
   logic                 lit;

   always_comb begin
      pattern = font_lookup(code_ff);
      if (scan_in.segment == SEG_POINT) begin
         lit = point_ff;
      end else begin
         lit = pattern[scan_in.segment];
      end
      token_in         = scan_in;
      token_in.mask    = scan_in.mask | (lit ? POS_BIT : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff        <= '0;
         point_ff       <= 1'b0;
         token_ff.valid <= 1'b0;
      end else begin
         if (wr.valid && (wr.index == MY_INDEX)) begin
            code_ff  <= wr.code;
            point_ff <= wr.point;
         end
         if (advance) begin
            token_ff <= token_in;
         end
      end
   end

   assign scan_out = token_ff;

endmodule

[rtl/core/seven_segment_scan_driver_top.sv]
// top level of the multiplexed seven-segment scan driver: prescaler, scan injector,
// chain of digit cells and result register; depends on ssd_pkg and ssd_digit_cell
//
//   channel  direction  handshake        carries
//   req_     in         valid / stall    req_type: mode, digit_index, char_code, point_on
//   rsp_     out        valid / stall    rsp_type: segment_number, digit_mask, last_scan
//   csr_     in         valid / ready    brightness write data, always ready
//
// a write, or a tick that does not refresh, completes as soon as it is taken
// a refreshing tick injects one token per segment; a token enters the cell chain each cycle
// unless rsp_ stalls, and crosses it through the DIGIT_COUNT cell registers to the result register
// no new item is taken until the last scan result of a refresh has been transferred
// a stall on rsp_ while a result is held freezes the whole cell chain; reset is synchronous and clears
// the prescaler, brightness and every stored digit
module seven_segment_scan_driver_top #(
   parameter int PERIOD_BASE = 16,
   parameter int PERIOD_STEP = 8,
   parameter int DIGIT_COUNT = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ssd_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ssd_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssd_pkg::BRIGHT_BITS-1:0]     csr_data
);
   import ssd_pkg::*;

   localparam int PERIOD_BITS = COUNT_BITS + 1;

   // configuration and prescaler
   logic [BRIGHT_BITS-1:0] brightness_ff;
   logic [COUNT_BITS-1:0]  prescale_ff;
   logic [COUNT_BITS-1:0]  prescale_in;
   logic [PERIOD_BITS-1:0] period;

   // scan injector: feeds eight segment tokens into the chain
   logic                   inj_active_ff;
   logic [SEG_BITS-1:0]    inj_seg_ff;

   // result register
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   advance;
   logic                   busy;
   logic                   req_take;
   logic                   refresh;
   wr_type                 wr;
   scan_type               chain [DIGIT_COUNT+1];
   logic [DIGIT_COUNT-1:0] cell_busy;

   // chain moves whenever the result register can take a new token
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign busy      = inj_active_ff || (|cell_busy) || rsp_valid_ff;
   assign req_stall = busy;
   assign req_take  = req_valid && !req_stall;
   assign refresh   = req_take && (req_payload.mode == MODE_TICK) && (prescale_ff == '0);

   assign csr_ready = 1'b1;

   // digit writes broadcast to all cells; an index with no cell is simply dropped
   assign wr.valid = req_take && (req_payload.mode == MODE_WRITE);
   assign wr.index = req_payload.digit_index;
   assign wr.code  = req_payload.char_code;
   assign wr.point = req_payload.point_on;

   // reload to minus the period, then the usual increment
   always_comb begin
      period = PERIOD_BITS'(PERIOD_BASE)
             + PERIOD_BITS'(PERIOD_STEP) * PERIOD_BITS'(brightness_ff);
      if (refresh) begin
         prescale_in = COUNT_BITS'(PERIOD_BITS'(1) - period);
      end else begin
         prescale_in = prescale_ff + COUNT_BITS'(1);
      end
   end

   // head of the chain: a fresh token with an empty mask
   assign chain[0].valid   = inj_active_ff;
   assign chain[0].segment = inj_seg_ff;
   assign chain[0].mask    = '0;

   for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
      ssd_digit_cell #(
         .POSITION (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .wr       (wr),
         .scan_in  (chain[i]),
         .scan_out (chain[i+1])
      );
      assign cell_busy[i] = chain[i+1].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= '0;
         prescale_ff   <= '0;
         inj_active_ff <= 1'b0;
         inj_seg_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            brightness_ff <= csr_data;
         end
         // ticks advance the prescaler, writes leave it alone
         if (req_take && (req_payload.mode == MODE_TICK)) begin
            prescale_ff <= prescale_in;
         end
         if (refresh) begin
            inj_active_ff <= 1'b1;
            inj_seg_ff    <= '0;
         end else if (inj_active_ff && advance) begin
            inj_seg_ff <= inj_seg_ff + SEG_BITS'(1);
            if (inj_seg_ff == SEG_POINT) begin
               inj_active_ff <= 1'b0;
            end
         end
         if (advance) begin
            rsp_valid_ff <= chain[DIGIT_COUNT].valid;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.segment_number <= chain[DIGIT_COUNT].segment;
         rsp_ff.digit_mask     <= chain[DIGIT_COUNT].mask;
         rsp_ff.last_scan      <= (chain[DIGIT_COUNT].segment == SEG_POINT);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // segments of one refresh leave back to back and in order
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_payload.last_scan) |=>
      (rsp_valid && (rsp_payload.segment_number == $past(rsp_payload.segment_number) + 3'd1)))
      else $error("scan results out of order or with a gap");

   // a refresh starts only from a prescaler at zero
   a_refresh_start: assert property (@(posedge clock) disable iff (reset)
      $rose(inj_active_ff) |-> ($past(prescale_ff) == '0))
      else $error("refresh started with prescaler not at zero");

   // no item enters while tokens are still being injected
   a_inject_blocks: assert property (@(posedge clock) disable iff (reset)
      inj_active_ff |-> req_stall)
      else $error("input open during scan injection");
`endif

endmodule
